/* rtl/cidc_pkg.sv */
// Shared constants and keyword functions for the distinct identifier counter.
package cidc_pkg;

  localparam logic [2:0] MODE_NORMAL  = 3'd0;
  localparam logic [2:0] MODE_BLOCK   = 3'd1;
  localparam logic [2:0] MODE_LINE    = 3'd2;
  localparam logic [2:0] MODE_CHAR    = 3'd3;
  localparam logic [2:0] MODE_STRING  = 3'd4;
  localparam logic [2:0] MODE_PREPROC = 3'd5;

  localparam logic [7:0] CH_BSLASH = 8'd92;
  localparam logic [7:0] CH_SQUOTE = 8'd39;
  localparam logic [7:0] CH_DQUOTE = 8'd34;
  localparam logic [7:0] CH_HASH   = 8'd35;
  localparam logic [7:0] CH_USCORE = 8'd95;
  localparam logic [7:0] CH_UPPER_A = 8'd65;
  localparam logic [7:0] CH_UPPER_Z = 8'd90;
  localparam logic [7:0] CH_LOWER_A = 8'd97;
  localparam logic [7:0] CH_LOWER_Z = 8'd122;
  localparam logic [7:0] CH_STAR   = 8'd42;
  localparam logic [7:0] CH_SLASH  = 8'd47;
  localparam logic [7:0] CH_NL     = 8'd10;
  localparam logic [7:0] CH_DIGIT0 = 8'd48;
  localparam logic [7:0] CH_DIGIT9 = 8'd57;

  localparam int KW_CNT = 32;
  localparam int KW_LEN = 8;

  // keyword bytes, first character in the low byte, zero padded
  function automatic logic [63:0] kw_word(input logic [4:0] idx);
    logic [63:0] w;
    w = '0;
    case (idx)
      5'd0:  w = {32'd0, "otua"};
      5'd1:  w = {24'd0, "kaerb"};
      5'd2:  w = {32'd0, "esac"};
      5'd3:  w = {32'd0, "rahc"};
      5'd4:  w = {24'd0, "tsnoc"};
      5'd5:  w = "eunitnoc";
      5'd6:  w = {8'd0, "tluafed"};
      5'd7:  w = {48'd0, "od"};
      5'd8:  w = {16'd0, "elbuod"};
      5'd9:  w = {32'd0, "esle"};
      5'd10: w = {32'd0, "mune"};
      5'd11: w = {16'd0, "nretxe"};
      5'd12: w = {24'd0, "taolf"};
      5'd13: w = {40'd0, "rof"};
      5'd14: w = {32'd0, "otog"};
      5'd15: w = {48'd0, "fi"};
      5'd16: w = {40'd0, "tni"};
      5'd17: w = {32'd0, "gnol"};
      5'd18: w = "retsiger";
      5'd19: w = {16'd0, "nruter"};
      5'd20: w = {24'd0, "trohs"};
      5'd21: w = {16'd0, "dengis"};
      5'd22: w = {16'd0, "foezis"};
      5'd23: w = {16'd0, "citats"};
      5'd24: w = {16'd0, "tcurts"};
      5'd25: w = {16'd0, "hctiws"};
      5'd26: w = {8'd0, "fedepyt"};
      5'd27: w = {24'd0, "noinu"};
      5'd28: w = "dengisnu";
      5'd29: w = {32'd0, "diov"};
      5'd30: w = "elitalov";
      5'd31: w = {24'd0, "elihw"};
      default: w = '0;
    endcase
    return w;
  endfunction

  function automatic logic [3:0] kw_len(input logic [4:0] idx);
    logic [3:0] n;
    case (idx)
      5'd7, 5'd15: n = 4'd2;
      5'd13, 5'd16: n = 4'd3;
      5'd0, 5'd2, 5'd3, 5'd9, 5'd10, 5'd14, 5'd17, 5'd29: n = 4'd4;
      5'd1, 5'd4, 5'd12, 5'd20, 5'd27, 5'd31: n = 4'd5;
      5'd8, 5'd11, 5'd19, 5'd21, 5'd22, 5'd23, 5'd24, 5'd25: n = 4'd6;
      5'd6, 5'd26: n = 4'd7;
      default: n = 4'd8;
    endcase
    return n;
  endfunction

endpackage

/* rtl/cidc_in_if.sv */
// Byte input channel.
interface cidc_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] char_code;
  logic       last_char;
  modport source (output valid, output char_code, output last_char, input ready);
  modport sink (input valid, input char_code, input last_char, output ready);
endinterface

/* rtl/cidc_out_if.sv */
// Result channel.
interface cidc_out_if;
  logic        valid;
  logic        ready;
  logic [10:0] distinct_count;
  logic        overflow;
  modport source (output valid, output distinct_count, output overflow, input ready);
  modport sink (input valid, input distinct_count, input overflow, output ready);
endinterface

/* rtl/c_identifier_distinct_counter.sv */
// Top level: scanner, word buffer and word table with a linear search.
//
// Usage: C source enters one byte per beat on in_ (char_code, last_char).
// The beat with last_char high produces one beat on out_: the number of
// distinct non-keyword identifiers and an overflow flag. No other beat
// produces a result. A byte that ends an identifier, and the last byte,
// start a word check: the keyword state compares the word against all
// keywords at once, then the stored entries are walked one at a time, each
// with a memory read state and then a compare state. A keyword or an empty
// word ends the check in the keyword state, and a new word on an empty table
// goes straight to the compare state; the single read port of the word table
// is why entries are compared one at a time. No byte is accepted during a
// word check. After the last byte the block waits until the receiver takes
// the result; while out_ stalls no byte is accepted.
// Reset (synchronous, active low) clears the scanner mode, the word and entry
// counts and the overflow flag; the table memory is not cleared, since only
// entries below the count are read.
// After a last byte the block returns to that same empty state.
module c_identifier_distinct_counter #(
  parameter int MAX_WORD_LEN = 64,
  parameter int TABLE_DEPTH  = 1024
) (
  input logic clk,
  input logic rst_n,
  cidc_in_if.sink    in_ch,
  cidc_out_if.source out_ch
);
  import cidc_pkg::*;

  localparam int WB = MAX_WORD_LEN * 8;
  localparam int LW = $clog2(MAX_WORD_LEN + 1);
  localparam int AW = $clog2(TABLE_DEPTH);
  localparam int CW = $clog2(TABLE_DEPTH + 1);
  localparam int PW = $clog2(MAX_WORD_LEN);
  localparam int SW = (CW > 11) ? CW : 11;

  localparam logic [10:0] CNT_SAT = 11'd2047;

  localparam logic [2:0] ST_IDLE = 3'd0;
  localparam logic [2:0] ST_KW   = 3'd1;
  localparam logic [2:0] ST_RD   = 3'd2;
  localparam logic [2:0] ST_CMP  = 3'd3;
  localparam logic [2:0] ST_OUT  = 3'd4;

  logic [2:0]    st_r, st_nxt;
  logic [2:0]    mode_r, mode_nxt;
  logic          esc_r, esc_nxt;
  logic          pss_r, pss_nxt;
  logic [WB-1:0] wbuf_r, wbuf_nxt;
  logic [LW-1:0] wlen_r, wlen_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          ovf_r, ovf_nxt;
  logic          fin_last_r, fin_last_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [10:0]   res_cnt_r, res_cnt_nxt;
  logic          res_ovf_r, res_ovf_nxt;

  logic [WB-1:0] tbl_mem [TABLE_DEPTH];
  logic [LW-1:0] len_mem [TABLE_DEPTH];
  logic [WB-1:0] tbl_rd_r;
  logic [LW-1:0] len_rd_r;
  logic          wr_en;
  logic [AW-1:0] wr_addr;

  // clamp the entry count to the width of the result field
  function automatic logic [10:0] sat_count(input logic [CW-1:0] n);
    logic [SW-1:0] e;
    e = SW'(n);
    return (e > SW'(CNT_SAT)) ? CNT_SAT : e[10:0];
  endfunction

  always_ff @(posedge clk) begin
    if (wr_en) begin
      tbl_mem[wr_addr] <= wbuf_r;
      len_mem[wr_addr] <= wlen_r;
    end
    tbl_rd_r <= tbl_mem[idx_r];
    len_rd_r <= len_mem[idx_r];
  end

  logic [7:0] c;
  logic       take;
  logic       fin;
  logic       is_alpha, is_digit, is_kw, is_match, more;
  logic [WB-1:0] mask;

  assign c = in_ch.char_code;
  assign take = in_ch.valid && in_ch.ready;
  assign in_ch.ready = (st_r == ST_IDLE);
  assign out_ch.valid = (st_r == ST_OUT);
  assign out_ch.distinct_count = res_cnt_r;
  assign out_ch.overflow = res_ovf_r;

  assign is_alpha = (c >= CH_UPPER_A && c <= CH_UPPER_Z) ||
                    (c >= CH_LOWER_A && c <= CH_LOWER_Z) || c == CH_USCORE;
  assign is_digit = (c >= CH_DIGIT0 && c <= CH_DIGIT9);

  // mask of valid buffer bits, compared against the stored entry
  always_comb begin
    mask = '0;
    for (int i = 0; i < MAX_WORD_LEN; i++) begin
      if (LW'(i) < wlen_r) mask[i*8 +: 8] = 8'hff;
    end
  end

  always_comb begin
    is_kw = 1'b0;
    for (int k = 0; k < KW_CNT; k++) begin
      if (wlen_r == LW'(kw_len(5'(k))) &&
          (wbuf_r[63:0] & mask[63:0]) == kw_word(5'(k))) is_kw = 1'b1;
    end
  end

  assign is_match = (len_rd_r == wlen_r) && ((tbl_rd_r & mask) == (wbuf_r & mask));
  assign more = (CW'(idx_r) + CW'(1)) < cnt_r;

  always_comb begin
    st_nxt = st_r;
    mode_nxt = mode_r;
    esc_nxt = esc_r;
    pss_nxt = pss_r;
    wbuf_nxt = wbuf_r;
    wlen_nxt = wlen_r;
    cnt_nxt = cnt_r;
    ovf_nxt = ovf_r;
    fin_last_nxt = fin_last_r;
    idx_nxt = idx_r;
    res_cnt_nxt = res_cnt_r;
    res_ovf_nxt = res_ovf_r;
    wr_en = 1'b0;
    wr_addr = cnt_r[AW-1:0];
    fin = 1'b0;
    case (st_r)
      ST_IDLE: begin
        if (take) begin
          if (esc_r) begin
            esc_nxt = 1'b0;
          end else if (c == CH_BSLASH) begin
            esc_nxt = 1'b1;
          end else begin
            case (mode_r)
              MODE_NORMAL: begin
                if (pss_r && c == CH_STAR) begin
                  pss_nxt = 1'b0;
                  mode_nxt = MODE_BLOCK;
                end else if (pss_r && c == CH_SLASH) begin
                  pss_nxt = 1'b0;
                  mode_nxt = MODE_LINE;
                end else begin
                  pss_nxt = 1'b0;
                  if (is_alpha || (wlen_r != '0 && is_digit)) begin
                    if (wlen_r < LW'(MAX_WORD_LEN)) begin
                      wbuf_nxt[wlen_r[PW-1:0]*8 +: 8] = c;
                      wlen_nxt = wlen_r + LW'(1);
                    end else begin
                      ovf_nxt = 1'b1;
                    end
                  end else begin
                    fin = 1'b1;
                    if (c == CH_SLASH) pss_nxt = 1'b1;
                    else if (c == CH_SQUOTE) mode_nxt = MODE_CHAR;
                    else if (c == CH_DQUOTE) mode_nxt = MODE_STRING;
                    else if (c == CH_HASH) mode_nxt = MODE_PREPROC;
                  end
                end
              end
              MODE_BLOCK: begin
                if (pss_r && c == CH_SLASH) begin
                  mode_nxt = MODE_NORMAL;
                  pss_nxt = 1'b0;
                end else begin
                  pss_nxt = (c == CH_STAR);
                end
              end
              MODE_LINE, MODE_PREPROC: if (c == CH_NL) mode_nxt = MODE_NORMAL;
              MODE_CHAR: if (c == CH_SQUOTE) mode_nxt = MODE_NORMAL;
              MODE_STRING: if (c == CH_DQUOTE) mode_nxt = MODE_NORMAL;
              default: mode_nxt = MODE_NORMAL;
            endcase
          end
          fin_last_nxt = in_ch.last_char;
          // check the word once the byte has been applied; skip an empty one
          if ((fin && wlen_r != '0) || in_ch.last_char) st_nxt = ST_KW;
        end
      end
      ST_KW: begin
        idx_nxt = '0;
        if (wlen_r == '0 || is_kw) begin
          wlen_nxt = '0;
          st_nxt = fin_last_r ? ST_OUT : ST_IDLE;
        end else if (cnt_r == '0) begin
          st_nxt = ST_CMP;
        end else begin
          st_nxt = ST_RD;
        end
        if (st_nxt == ST_OUT) begin
          res_cnt_nxt = sat_count(cnt_r);
          res_ovf_nxt = ovf_r;
        end
      end
      ST_RD: st_nxt = ST_CMP;
      ST_CMP: begin
        if (cnt_r != '0 && is_match) begin
          wlen_nxt = '0;
          st_nxt = fin_last_r ? ST_OUT : ST_IDLE;
          res_cnt_nxt = sat_count(cnt_r);
          res_ovf_nxt = ovf_r;
        end else if (cnt_r != '0 && more) begin
          idx_nxt = idx_r + AW'(1);
          st_nxt = ST_RD;
        end else begin
          wlen_nxt = '0;
          if (cnt_r < CW'(TABLE_DEPTH)) begin
            wr_en = 1'b1;
            cnt_nxt = cnt_r + CW'(1);
          end else begin
            ovf_nxt = 1'b1;
          end
          st_nxt = fin_last_r ? ST_OUT : ST_IDLE;
          res_cnt_nxt = sat_count(cnt_nxt);
          res_ovf_nxt = ovf_nxt;
        end
      end
      ST_OUT: begin
        if (out_ch.ready) begin
          st_nxt = ST_IDLE;
          mode_nxt = MODE_NORMAL;
          esc_nxt = 1'b0;
          pss_nxt = 1'b0;
          wlen_nxt = '0;
          cnt_nxt = '0;
          ovf_nxt = 1'b0;
        end
      end
      default: st_nxt = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= ST_IDLE;
      mode_r <= MODE_NORMAL;
      esc_r <= 1'b0;
      pss_r <= 1'b0;
      wlen_r <= '0;
      cnt_r <= '0;
      ovf_r <= 1'b0;
      fin_last_r <= 1'b0;
      idx_r <= '0;
    end else begin
      st_r <= st_nxt;
      mode_r <= mode_nxt;
      esc_r <= esc_nxt;
      pss_r <= pss_nxt;
      wlen_r <= wlen_nxt;
      cnt_r <= cnt_nxt;
      ovf_r <= ovf_nxt;
      fin_last_r <= fin_last_nxt;
      idx_r <= idx_nxt;
    end
  end

  always_ff @(posedge clk) begin
    wbuf_r <= wbuf_nxt;
    res_cnt_r <= res_cnt_nxt;
    res_ovf_r <= res_ovf_nxt;
  end

endmodule
